### hw/rtl/fbalu_pkg.sv
// fbalu_pkg: shared widths, command/opcode/status codes and structs for the
// four register byte alu. No dependencies.
`default_nettype none

package fbalu_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned NumRegs = 4;
  localparam int unsigned IdxW = $clog2(NumRegs);
  localparam int unsigned CodeW = 2;
  // raw result: sign bit plus room for the largest product
  localparam int unsigned RawW = 2 * DataW + 1;
  localparam int unsigned CntW = $clog2(DataW + 1);
  localparam logic [RawW-1:0] Correction = RawW'(255);

  localparam logic [CodeW-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CodeW-1:0] CMD_OPERATE = 2'd1;
  localparam logic [CodeW-1:0] CMD_READ    = 2'd2;

  localparam logic [CodeW-1:0] OP_ADD = 2'd0;
  localparam logic [CodeW-1:0] OP_SUB = 2'd1;
  localparam logic [CodeW-1:0] OP_MUL = 2'd2;
  localparam logic [CodeW-1:0] OP_DIV = 2'd3;

  localparam logic [CodeW-1:0] STAT_OK      = 2'd0;
  localparam logic [CodeW-1:0] STAT_BLOCKED = 2'd1;
  localparam logic [CodeW-1:0] STAT_DIVZERO = 2'd2;

  typedef struct packed {
    logic             start;
    logic [CodeW-1:0] op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } core_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
    logic             carry;
  } core_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/fbalu_if.sv
// fbalu_cmd_if / fbalu_rsp_if: valid/ready channels for commands and results.
// Depends on fbalu_pkg for field widths.
`default_nettype none

interface fbalu_cmd_if import fbalu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] cmd;
  logic [IdxW-1:0]  first_index;
  logic [IdxW-1:0]  second_index;
  logic [CodeW-1:0] opcode;
  logic [DataW-1:0] write_value;

  modport source (output valid, cmd, first_index, second_index, opcode, write_value,
                  input ready);
  modport sink (input valid, cmd, first_index, second_index, opcode, write_value,
                output ready);
endinterface

interface fbalu_rsp_if import fbalu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] result_byte;
  logic             carry_flag;
  logic [CodeW-1:0] status;

  modport source (output valid, result_byte, carry_flag, status, input ready);
  modport sink (input valid, result_byte, carry_flag, status, output ready);
endinterface

`default_nettype wire

### hw/rtl/four_register_byte_alu.sv
// four_register_byte_alu: top level with register file, command sequencer and
// result register. Depends on fbalu_pkg, fbalu_if and fbalu_core.
//
//   channel  dir  modport        carries
//   cmd_i    in   fbalu_cmd_if   cmd, first_index, second_index, opcode, write_value
//   rsp_o    out  fbalu_rsp_if   result_byte, carry_flag, status
//
// write, read, blocked operate and unused command: result registered in the
// cycle after the transaction. operate: first and second operand fetched in
// turn through the single register file read port, then the shared core (one
// step for add/sub, eight for multiply/divide, one correction step, then
// the registered done), then the result register. divide by zero is caught
// in the second fetch, before the core is started.
// reset clears the register file, last result/carry and unlocks operations.
// one command at a time; a new command is taken once the sequencer is idle and
// the result register is empty or being drained in the same cycle.
`default_nettype none

module four_register_byte_alu import fbalu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbalu_cmd_if.sink   cmd_i,
  fbalu_rsp_if.source rsp_o
);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOAD_A = 2'd1;
  localparam logic [1:0] ST_LOAD_B = 2'd2;
  localparam logic [1:0] ST_WAIT   = 2'd3;

  logic [1:0]       st_q, st_d;

  // architectural state
  logic [DataW-1:0] rf_q [NumRegs];
  logic [DataW-1:0] rf_d [NumRegs];
  logic [DataW-1:0] last_res_q, last_res_d;
  logic             last_carry_q, last_carry_d;
  logic             allowed_q, allowed_d;

  // captured operate command
  logic [IdxW-1:0]  ia_q, ia_d;
  logic [IdxW-1:0]  ib_q, ib_d;
  logic [CodeW-1:0] op_q, op_d;
  logic [DataW-1:0] a_q, a_d;

  // result register
  logic             ovalid_q, ovalid_d;
  logic [DataW-1:0] obyte_q, obyte_d;
  logic             ocarry_q, ocarry_d;
  logic [CodeW-1:0] ostat_q, ostat_d;

  logic             accept;
  logic [IdxW-1:0]  rd_idx;
  logic [DataW-1:0] rd_val;
  core_req_t        core_req;
  core_rsp_t        core_rsp;

  // take a command only when idle and the result slot frees up
  assign cmd_i.ready = (st_q == ST_IDLE) && (!ovalid_q || rsp_o.ready);
  assign accept      = cmd_i.valid && cmd_i.ready;

  // single read port on the register file, first operand then second
  assign rd_idx = (st_q == ST_LOAD_A) ? ia_q : ib_q;
  assign rd_val = rf_q[rd_idx];

  always_comb begin
    st_d         = st_q;
    rf_d         = rf_q;
    last_res_d   = last_res_q;
    last_carry_d = last_carry_q;
    allowed_d    = allowed_q;
    ia_d         = ia_q;
    ib_d         = ib_q;
    op_d         = op_q;
    a_d          = a_q;
    ovalid_d     = ovalid_q && !rsp_o.ready;
    obyte_d      = obyte_q;
    ocarry_d     = ocarry_q;
    ostat_d      = ostat_q;
    core_req     = '{start: 1'b0, op: op_q, a: a_q, b: rd_val};

    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          // default result: zeros with status ok
          ovalid_d = 1'b1;
          obyte_d  = '0;
          ocarry_d = 1'b0;
          ostat_d  = STAT_OK;
          case (cmd_i.cmd)
            CMD_WRITE: rf_d[cmd_i.first_index] = cmd_i.write_value;
            CMD_OPERATE: begin
              if (!allowed_q) begin
                ostat_d = STAT_BLOCKED;
              end else begin
                // no result yet, the operation runs first
                ovalid_d = 1'b0;
                ia_d     = cmd_i.first_index;
                ib_d     = cmd_i.second_index;
                op_d     = cmd_i.opcode;
                st_d     = ST_LOAD_A;
              end
            end
            CMD_READ: begin
              allowed_d = 1'b1;
              obyte_d   = last_res_q;
              ocarry_d  = last_carry_q;
            end
            default: ostat_d = STAT_OK;
          endcase
        end
      end
      ST_LOAD_A: begin
        a_d  = rd_val;
        st_d = ST_LOAD_B;
      end
      ST_LOAD_B: begin
        if (op_q == OP_DIV && rd_val == '0) begin
          // divide by zero leaves everything as it was
          ovalid_d = 1'b1;
          obyte_d  = '0;
          ocarry_d = 1'b0;
          ostat_d  = STAT_DIVZERO;
          st_d     = ST_IDLE;
        end else begin
          core_req.start = 1'b1;
          st_d           = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (core_rsp.done) begin
          last_res_d   = core_rsp.result;
          last_carry_d = core_rsp.carry;
          allowed_d    = 1'b0;
          ovalid_d     = 1'b1;
          obyte_d      = core_rsp.result;
          ocarry_d     = core_rsp.carry;
          ostat_d      = STAT_OK;
          st_d         = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  fbalu_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (core_req),
    .rsp_o  (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      for (int i = 0; i < NumRegs; i++) rf_q[i] <= '0;
      last_res_q   <= '0;
      last_carry_q <= 1'b0;
      allowed_q    <= 1'b1;
      ovalid_q     <= 1'b0;
    end else begin
      st_q         <= st_d;
      rf_q         <= rf_d;
      last_res_q   <= last_res_d;
      last_carry_q <= last_carry_d;
      allowed_q    <= allowed_d;
      ovalid_q     <= ovalid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    ia_q     <= ia_d;
    ib_q     <= ib_d;
    op_q     <= op_d;
    a_q      <= a_d;
    obyte_q  <= obyte_d;
    ocarry_q <= ocarry_d;
    ostat_q  <= ostat_d;
  end

  assign rsp_o.valid       = ovalid_q;
  assign rsp_o.result_byte = obyte_q;
  assign rsp_o.carry_flag  = ocarry_q;
  assign rsp_o.status      = ostat_q;

endmodule

`default_nettype wire

### hw/rtl/fbalu_core.sv
// fbalu_core: iterative arithmetic unit around one shared adder/subtractor.
// add/sub in one step, shift-add multiply and restoring divide in eight,
// then a correction step. Depends on fbalu_pkg.
`default_nettype none

module fbalu_core import fbalu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  core_req_t req_i,
  output core_rsp_t rsp_o
);

  localparam logic [1:0] CORE_IDLE = 2'd0;
  localparam logic [1:0] CORE_RUN  = 2'd1;
  localparam logic [1:0] CORE_FIX  = 2'd2;

  logic [1:0]         st_q, st_d;
  logic [CodeW-1:0]   op_q, op_d;
  logic [DataW-1:0]   a_q, a_d;
  logic [DataW-1:0]   b_q, b_d;
  logic [RawW-1:0]    acc_q, acc_d;
  logic [2*DataW-1:0] mcand_q, mcand_d;
  logic [DataW-1:0]   mplier_q, mplier_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DataW-1:0]   res_q, res_d;
  logic               carry_q, carry_d;
  logic               done_q, done_d;

  logic [RawW-1:0]  add_x, add_y, sum;
  logic             add_sub;
  logic [DataW:0]   rem_shift;
  logic [RawW-1:0]  fix_val;
  logic             too_big, too_small;

  assign rem_shift = {acc_q[DataW-1:0], mplier_q[DataW-1]};
  assign fix_val   = (op_q == OP_DIV) ? {{(RawW-DataW){1'b0}}, mplier_q} : acc_q;
  assign too_small = fix_val[RawW-1];
  assign too_big   = !fix_val[RawW-1] && (fix_val > Correction);

  // the one shared adder
  always_comb begin
    add_x   = {{(RawW-DataW){1'b0}}, a_q};
    add_y   = {{(RawW-DataW){1'b0}}, b_q};
    add_sub = 1'b0;
    if (st_q == CORE_FIX) begin
      add_x   = fix_val;
      add_y   = Correction;
      add_sub = !too_small;
    end else begin
      case (op_q)
        OP_ADD: add_sub = 1'b0;
        OP_SUB: add_sub = 1'b1;
        OP_MUL: begin
          add_x = acc_q;
          add_y = {1'b0, mcand_q};
        end
        default: begin
          add_x   = {{(RawW-DataW-1){1'b0}}, rem_shift};
          add_sub = 1'b1;
        end
      endcase
    end
    sum = add_x + (add_y ^ {RawW{add_sub}}) + RawW'(add_sub);
  end

  always_comb begin
    st_d     = st_q;
    op_d     = op_q;
    a_d      = a_q;
    b_d      = b_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    res_d    = res_q;
    carry_d  = carry_q;
    done_d   = 1'b0;
    case (st_q)
      CORE_IDLE: begin
        if (req_i.start) begin
          op_d     = req_i.op;
          a_d      = req_i.a;
          b_d      = req_i.b;
          acc_d    = '0;
          mcand_d  = {{DataW{1'b0}}, req_i.a};
          mplier_d = (req_i.op == OP_DIV) ? req_i.a : req_i.b;
          cnt_d    = (req_i.op == OP_ADD || req_i.op == OP_SUB) ?
                     CntW'(1) : CntW'(DataW);
          st_d     = CORE_RUN;
        end
      end
      CORE_RUN: begin
        case (op_q)
          OP_ADD, OP_SUB: acc_d = sum;
          OP_MUL: begin
            if (mplier_q[0]) acc_d = sum;
            mcand_d  = {mcand_q[2*DataW-2:0], 1'b0};
            mplier_d = {1'b0, mplier_q[DataW-1:1]};
          end
          default: begin
            // restoring step: keep the difference when it did not go negative
            if (!sum[RawW-1]) begin
              acc_d = {{(RawW-DataW){1'b0}}, sum[DataW-1:0]};
            end else begin
              acc_d = {{(RawW-DataW){1'b0}}, rem_shift[DataW-1:0]};
            end
            mplier_d = {mplier_q[DataW-2:0], !sum[RawW-1]};
          end
        endcase
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) st_d = CORE_FIX;
      end
      CORE_FIX: begin
        carry_d = too_big || too_small;
        res_d   = (too_big || too_small) ? sum[DataW-1:0] : fix_val[DataW-1:0];
        done_d  = 1'b1;
        st_d    = CORE_IDLE;
      end
      default: st_d = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= CORE_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    a_q      <= a_d;
    b_q      <= b_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    cnt_q    <= cnt_d;
    res_q    <= res_d;
    carry_q  <= carry_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;
  assign rsp_o.carry  = carry_q;

endmodule

`default_nettype wire

### hw/rtl/fbalu_checker.sv
// fbalu_checker: port-level assertions for four_register_byte_alu, attached
// by bind at the end of this file. Depends on fbalu_pkg.
`default_nettype none

module fbalu_checker import fbalu_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [CodeW-1:0] in_cmd_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [DataW-1:0] out_byte_i,
  input logic             out_carry_i,
  input logic [CodeW-1:0] out_status_i
);

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transaction");

  // no new command while a pending result is not drained
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> (!out_valid_i || out_ready_i))
    else $error("command taken over an undrained result");

  // a register write answers next cycle with zeros and ok
  a_write_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_cmd_i == CMD_WRITE |=>
      out_valid_i && out_byte_i == '0 && !out_carry_i && out_status_i == STAT_OK)
    else $error("bad write response");

  // a read answers next cycle with status ok
  a_read_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_cmd_i == CMD_READ |=>
      out_valid_i && out_status_i == STAT_OK)
    else $error("bad read response");

endmodule

bind four_register_byte_alu fbalu_checker u_fbalu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (cmd_i.valid),
  .in_ready_i   (cmd_i.ready),
  .in_cmd_i     (cmd_i.cmd),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_byte_i   (rsp_o.result_byte),
  .out_carry_i  (rsp_o.carry_flag),
  .out_status_i (rsp_o.status)
);

`default_nettype wire
